@@ rtl/core/elg_pkg.sv @@
// Shared constants for the ElGamal signature engine.
package elg_pkg;
    localparam int WIDTH_DEF = 16;
    localparam int REG_W = 16;

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_PRIVATE = 2'd2;
    localparam logic [1:0] REG_PUBLIC = 2'd3;

    localparam logic OP_SIGN = 1'b0;
    localparam logic OP_VERIFY = 1'b1;
endpackage

@@ rtl/core/elg_if.sv @@
// Valid/ready channel interfaces for request and result items.
interface elg_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] message;
    logic [15:0] nonce;
    logic [15:0] nonce_inverse;
    logic [15:0] sig_first_in;
    logic [15:0] sig_second_in;
    modport source (output valid, operation, message, nonce, nonce_inverse,
                    sig_first_in, sig_second_in, input ready);
    modport sink (input valid, operation, message, nonce, nonce_inverse,
                  sig_first_in, sig_second_in, output ready);
endinterface

interface elg_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] sig_first;
    logic [15:0] sig_second;
    logic        valid_res;
    modport source (output valid, sig_first, sig_second, valid_res, input ready);
    modport sink (input valid, sig_first, sig_second, valid_res, output ready);
endinterface

@@ rtl/core/elg_modmul.sv @@
// Bit-serial modular multiplier: r = a*b mod m, one bit of b per cycle, MSB first.
module elg_modmul
    import elg_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] m,
    output logic             done,
    output logic [WIDTH-1:0] r
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH+1:0] dbl, dred, add, ared;

    // a is assumed already reduced below m
    always_comb
    begin
        dbl  = {1'b0, acc_reg, 1'b0};
        dred = (dbl >= {2'b00, m}) ? dbl - {2'b00, m} : dbl;
        add  = dred + (b_reg[WIDTH-1] ? {2'b00, a} : '0);
        ared = (add >= {2'b00, m}) ? add - {2'b00, m} : add;
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            b_next    = b;
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = ared[WIDTH-1:0];
            b_next   = {b_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign r    = acc_reg;
endmodule

@@ rtl/core/elgamal_sign_verify_top.sv @@
// ElGamal sign/verify engine top level with sequencer.
//
// Usage: configure modulus p, generator, private key and public key through
// the write port (index 0..3) while idle. Send one request on req: operation
// 0 signs (message, nonce, nonce_inverse), 1 verifies (message, sig_first_in,
// sig_second_in). Exactly one result follows on res.
// All products and reductions run through one bit-serial modular multiplier;
// a product is issued, steps through each bit of b and then signals done.
// Reducing an operand is a product by one. Each exponent bit costs a square,
// plus a multiply by the base when the bit is set, then a bit step.
// Sign takes seven products and one exponentiation by the nonce; verify takes
// four products and three exponentiations, by gamma, delta and the message;
// each exponentiation walks all WIDTH bits of its exponent.
// One item at a time; req.ready is high only when idle and the result
// register is empty. A stalled receiver holds the result in its output
// register and the next item waits until it is taken.
// Reset returns the registers to p=3, generator 2, private key 0, public
// key 1, and empties the engine. A modulus below 3 gives an all-zero result.
module elgamal_sign_verify_top
    import elg_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [REG_W-1:0] cfg_data,
    elg_req_if.sink          req,
    elg_res_if.source        res
);
    localparam int CW = $clog2(WIDTH + 1);

    // sign plan
    localparam logic [2:0] SG_BASE  = 3'd0;   // alpha mod p
    localparam logic [2:0] SG_GAMMA = 3'd1;   // alpha^k mod p
    localparam logic [2:0] SG_KEY   = 3'd2;   // private key mod q
    localparam logic [2:0] SG_GRED  = 3'd3;   // gamma mod q
    localparam logic [2:0] SG_KG    = 3'd4;   // key*gamma mod q
    localparam logic [2:0] SG_DIFF  = 3'd5;   // message mod q minus key*gamma
    localparam logic [2:0] SG_KINV  = 3'd6;   // nonce inverse mod q
    localparam logic [2:0] SG_DELTA = 3'd7;   // difference * inverse mod q
    // verify plan
    localparam logic [2:0] VF_BETA  = 3'd0;   // beta mod p
    localparam logic [2:0] VF_Y1    = 3'd1;   // beta^gamma
    localparam logic [2:0] VF_GRED  = 3'd2;   // gamma mod p
    localparam logic [2:0] VF_Y2    = 3'd3;   // gamma^delta
    localparam logic [2:0] VF_Y12   = 3'd4;   // y1*y2 mod p
    localparam logic [2:0] VF_ALPHA = 3'd5;   // alpha mod p
    localparam logic [2:0] VF_Y3    = 3'd6;   // alpha^message, compare

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PREP  = 10'b0000000010,
        S_MUL   = 10'b0000000100,
        S_MULW  = 10'b0000001000,
        S_SQ    = 10'b0000010000,
        S_SQW   = 10'b0000100000,
        S_ML    = 10'b0001000000,
        S_MLW   = 10'b0010000000,
        S_BIT   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    function automatic logic is_exp(input logic op, input logic [2:0] step);
        if (op == OP_SIGN)
            return step == SG_GAMMA;
        return (step == VF_Y1) || (step == VF_Y2) || (step == VF_Y3);
    endfunction

    state_t state_reg, state_next;

    logic [REG_W-1:0] mod_reg, gen_reg, priv_reg, pub_reg;
    logic [WIDTH-1:0] p, q;
    logic             op_reg;
    logic [WIDTH-1:0] msg_reg, k_reg, kinv_reg, gm_reg, dt_reg;
    logic [WIDTH-1:0] base_reg, acc_reg, e_reg, t0_reg, t1_reg;
    logic [CW-1:0]    bit_reg;
    logic [2:0]       step_reg, step_next, step_inc;
    logic [WIDTH-1:0] mm_a, mm_b, mm_m, mm_r;
    logic             mm_start, mm_done;
    logic [WIDTH-1:0] o_first_reg, o_second_reg;
    logic             o_ok_reg, o_valid_reg;
    logic             exp_next, last_step, use_q, exp_last, adv;
    logic [WIDTH-1:0] exp_src, diff, plain_a, plain_b;

    assign p = WIDTH'(mod_reg);
    assign q = p - WIDTH'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= REG_W'(3);
            gen_reg  <= REG_W'(2);
            priv_reg <= '0;
            pub_reg  <= REG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS:   mod_reg  <= cfg_data;
                REG_GENERATOR: gen_reg  <= cfg_data;
                REG_PRIVATE:   priv_reg <= cfg_data;
                REG_PUBLIC:    pub_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    elg_modmul #(.WIDTH(WIDTH)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .m     (mm_m),
        .done  (mm_done),
        .r     (mm_r)
    );

    assign req.ready = (state_reg == S_IDLE) && !o_valid_reg;
    assign res.valid = o_valid_reg;
    assign res.sig_first  = 16'(o_first_reg);
    assign res.sig_second = 16'(o_second_reg);
    assign res.valid_res  = o_ok_reg;

    assign step_inc  = step_reg + 3'd1;
    assign exp_next  = is_exp(op_reg, step_inc);
    assign last_step = (op_reg == OP_SIGN) ? (step_reg == SG_DELTA) : (step_reg == VF_Y3);
    assign use_q     = (op_reg == OP_SIGN) && (step_reg != SG_BASE) && (step_reg != SG_GAMMA);
    assign exp_last  = (bit_reg == CW'(1));
    assign adv       = ((state_reg == S_MULW) && mm_done) || ((state_reg == S_BIT) && exp_last);
    // both operands are below q here, so one correction suffices
    assign diff      = (mm_r >= t0_reg) ? mm_r - t0_reg : mm_r + (q - t0_reg);

    // exponent of the next exponentiation step
    always_comb
    begin
        exp_src = msg_reg;
        if (op_reg == OP_SIGN)
            exp_src = k_reg;
        else if (step_inc == VF_Y1)
            exp_src = gm_reg;
        else if (step_inc == VF_Y2)
            exp_src = dt_reg;
    end

    // operands of plain products; a reduction is a product by one
    always_comb
    begin
        plain_a = WIDTH'(1);
        plain_b = '0;
        if (op_reg == OP_SIGN)
        begin
            case (step_reg)
                SG_BASE:  plain_b = WIDTH'(gen_reg);
                SG_KEY:   plain_b = WIDTH'(priv_reg);
                SG_GRED:  plain_b = o_first_reg;
                SG_KG:
                begin
                    plain_a = t0_reg;
                    plain_b = t1_reg;
                end
                SG_DIFF:  plain_b = msg_reg;
                SG_KINV:  plain_b = kinv_reg;
                SG_DELTA:
                begin
                    plain_a = t1_reg;
                    plain_b = t0_reg;
                end
                default: ;
            endcase
        end
        else
        begin
            case (step_reg)
                VF_BETA:  plain_b = WIDTH'(pub_reg);
                VF_GRED:  plain_b = gm_reg;
                VF_Y12:
                begin
                    plain_a = t0_reg;
                    plain_b = t1_reg;
                end
                VF_ALPHA: plain_b = WIDTH'(gen_reg);
                default: ;
            endcase
        end
    end

    // a and m stay put for the whole product
    always_comb
    begin
        mm_a = plain_a;
        mm_b = plain_b;
        mm_m = use_q ? q : p;
        if ((state_reg == S_SQ) || (state_reg == S_SQW))
        begin
            mm_a = acc_reg;
            mm_b = acc_reg;
        end
        else if ((state_reg == S_ML) || (state_reg == S_MLW))
        begin
            mm_a = base_reg;
            mm_b = acc_reg;
        end
    end

    assign mm_start = (state_reg == S_MUL) || (state_reg == S_SQ) || (state_reg == S_ML);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
                if (req.valid && req.ready)
                begin
                    state_next = S_PREP;
                    step_next  = '0;
                end
            S_PREP:
                if (p < WIDTH'(3))
                    state_next = S_OUT;
                else
                    state_next = S_MUL;
            S_MUL:
                state_next = S_MULW;
            S_MULW: ;
            S_SQ:
                state_next = S_SQW;
            S_SQW:
                if (mm_done)
                begin
                    if (e_reg[WIDTH-1])
                        state_next = S_ML;
                    else
                        state_next = S_BIT;
                end
            S_ML:
                state_next = S_MLW;
            S_MLW:
                if (mm_done)
                    state_next = S_BIT;
            S_BIT:
                if (!exp_last)
                    state_next = S_SQ;
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        if (adv)
        begin
            if (last_step)
                state_next = S_OUT;
            else
            begin
                step_next  = step_inc;
                state_next = exp_next ? S_SQ : S_MUL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            o_valid_reg <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == S_OUT)
                o_valid_reg <= 1'b1;
            else if (res.valid && res.ready)
                o_valid_reg <= 1'b0;
        end
    end

    // registered updates of the datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid && req.ready)
        begin
            op_reg   <= req.operation;
            msg_reg  <= WIDTH'(req.message);
            k_reg    <= WIDTH'(req.nonce);
            kinv_reg <= WIDTH'(req.nonce_inverse);
            gm_reg   <= WIDTH'(req.sig_first_in);
            dt_reg   <= WIDTH'(req.sig_second_in);
        end
        if (state_reg == S_PREP)
        begin
            o_first_reg  <= '0;
            o_second_reg <= '0;
            o_ok_reg     <= 1'b0;
        end
        if (state_reg == S_MULW && mm_done)
        begin
            if (op_reg == OP_SIGN)
            begin
                case (step_reg)
                    SG_BASE:  base_reg <= mm_r;
                    SG_KEY:   t0_reg <= mm_r;
                    SG_GRED:  t1_reg <= mm_r;
                    SG_KG:    t0_reg <= mm_r;
                    SG_DIFF:  t1_reg <= diff;
                    SG_KINV:  t0_reg <= mm_r;
                    SG_DELTA: o_second_reg <= mm_r;
                    default: ;
                endcase
            end
            else
            begin
                case (step_reg)
                    VF_Y12:  t0_reg <= mm_r;
                    default: base_reg <= mm_r;
                endcase
            end
        end
        if ((state_reg == S_SQW || state_reg == S_MLW) && mm_done)
            acc_reg <= mm_r;
        if (state_reg == S_BIT)
        begin
            e_reg   <= {e_reg[WIDTH-2:0], 1'b0};
            bit_reg <= bit_reg - CW'(1);
            if (exp_last)
            begin
                if (op_reg == OP_SIGN)
                    o_first_reg <= acc_reg;
                else
                begin
                    case (step_reg)
                        VF_Y1:   t0_reg <= acc_reg;
                        VF_Y2:   t1_reg <= acc_reg;
                        default: o_ok_reg <= (acc_reg == t0_reg);
                    endcase
                end
            end
        end
        // an exponentiation never follows another, so this never meets the shift above
        if (adv && !last_step && exp_next)
        begin
            acc_reg <= WIDTH'(1);
            e_reg   <= exp_src;
            bit_reg <= CW'(WIDTH);
        end
    end
endmodule
